// ===== src/mf5x5_pkg.sv =====
// Shared types, register codes and constants of the 5x5 maximum filter.
`timescale 1ns / 1ps

package mf5x5_pkg;

  localparam int PIX_W = 8;
  typedef logic [PIX_W-1:0] pixel_t;

  localparam int FW_W  = 11;
  localparam int FH_W  = 12;
  localparam int CFG_W = 12;
  localparam int H_MAX = 4095;

  localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 12'd480;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_FRAME_WIDTH  = 1'b0;
  localparam reg_idx_t REG_FRAME_HEIGHT = 1'b1;

  function automatic pixel_t max2(pixel_t a, pixel_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== src/mf5x5_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module mf5x5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/max_filter_5x5.sv =====
// Top level of the clipped-window maximum (grayscale dilation) filter.
//
//   port group   dir  contents
//   s_axis_*     in   tdata: pixel_value; tuser: action (1 = flush item)
//   m_axis_*     out  tdata: max_value; tlast: frame_last
//   cfg_*        in   cfg_index 0 = frame_width, 1 = frame_height
//
// One item enters per cycle unless the output stalls; the item that completes a
// window, 2*width+2 items after its center pixel, passes s1, s2, s3 and the output.
// The line RAM holds the previous 2*RADIUS rows per column and is read and
// written back once per item; a width of one forwards the last written word.
// Reset is synchronous; the line RAM is not cleared since clipping never uses
// a row that this frame has not written. A stalled output freezes the whole
// pipeline, and the input is ready whenever the output register can move.
`timescale 1ns / 1ps

module max_filter_5x5 #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  mf5x5_pkg::pixel_t        s_axis_tdata,   // [7:0] pixel_value
  input  logic                     s_axis_tuser,   // [0] action
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output mf5x5_pkg::pixel_t        m_axis_tdata,   // [7:0] max_value
  output logic                     m_axis_tlast,
  input  logic                     cfg_we,
  input  mf5x5_pkg::reg_idx_t      cfg_index,
  input  logic [mf5x5_pkg::CFG_W-1:0] cfg_data
);

  import mf5x5_pkg::*;

  localparam int NR  = 2 * RADIUS + 1;
  localparam int NL  = 2 * RADIUS;
  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int LW  = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int IRW = $clog2(H_MAX + 2 * RADIUS + 1);

  // Configuration.
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic [LW-1:0]   lat;

  // Input-side counters.
  logic [CB-1:0]   in_col;
  logic [IRW-1:0]  in_row;
  logic [LW-1:0]   lead;
  logic [CB-1:0]   out_col;
  logic [FH_W-1:0] out_row;

  logic ce;
  logic accept;
  logic emit;
  logic q_last;
  logic pix_ok;
  logic in_row_end;
  logic [NR-1:0] rmask;
  logic [NR-1:0] cmask;

  // Pipeline.
  logic          s1_valid, s1_emit, s1_last, s1_fwd;
  logic [CB-1:0] s1_col;
  pixel_t        s1_pix;
  logic [NR-1:0] s1_rmask, s1_cmask;
  logic [NL*PIX_W-1:0] fwd_word;
  logic [NL*PIX_W-1:0] rd_word;
  logic [NL*PIX_W-1:0] col_word;
  pixel_t [NR-1:0] vec;

  pixel_t [NR-1:0][NR-1:0] win;
  logic          s2_emit, s2_last;
  logic [NR-1:0] s2_rmask, s2_cmask;
  pixel_t [NR-1:0] colmax_next;

  logic          s3_emit, s3_last;
  logic [NR-1:0] s3_cmask;
  pixel_t [NR-1:0] colmax;
  pixel_t        best;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
    lat   = LW'(32'(RADIUS) * 32'(w_eff) + 32'(RADIUS));
  end

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;
  assign accept        = s_axis_tvalid && ce;

  always_comb begin
    emit       = (lead == lat);
    q_last     = (32'(out_row) + 32'd1 == 32'(h_eff)) &&
                 (32'(out_col) + 32'd1 == 32'(w_eff));
    pix_ok     = 32'(in_row) < 32'(h_eff);
    in_row_end = (32'(in_col) + 32'd1 == 32'(w_eff));
    // Row i of the column vector is row out_row+RADIUS-i; column j of the
    // window is column out_col+RADIUS-j. Both are clipped to the frame.
    for (int i = 0; i < NR; i++) begin
      rmask[i] = (32'(out_row) + 32'(RADIUS) >= 32'(i)) &&
                 (32'(out_row) + 32'(RADIUS) < 32'(h_eff) + 32'(i));
      cmask[i] = (32'(out_col) + 32'(RADIUS) >= 32'(i)) &&
                 (32'(out_col) + 32'(RADIUS) < 32'(w_eff) + 32'(i));
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= WIDTH_RESET;
      frame_height  <= HEIGHT_RESET;
      in_col        <= '0;
      in_row        <= '0;
      lead          <= '0;
      out_col       <= '0;
      out_row       <= '0;
      s1_valid      <= 1'b0;
      s1_emit       <= 1'b0;
      s2_emit       <= 1'b0;
      s3_emit       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        endcase
        in_col  <= '0;
        in_row  <= '0;
        lead    <= '0;
        out_col <= '0;
        out_row <= '0;
      end else if (accept) begin
        if (emit && q_last) begin
          in_col  <= '0;
          in_row  <= '0;
          lead    <= '0;
          out_col <= '0;
          out_row <= '0;
        end else begin
          if (in_row_end) begin
            in_col <= '0;
            in_row <= in_row + IRW'(1);
          end else begin
            in_col <= in_col + CB'(1);
          end
          if (!emit) begin
            lead <= lead + LW'(1);
          end else if (32'(out_col) + 32'd1 == 32'(w_eff)) begin
            out_col <= '0;
            out_row <= out_row + FH_W'(1);
          end else begin
            out_col <= out_col + CB'(1);
          end
        end
      end
      if (ce) begin
        s1_valid      <= accept;
        s1_emit       <= accept && emit;
        s2_emit       <= s1_emit;
        s3_emit       <= s2_emit;
        m_axis_tvalid <= s3_emit;
      end
    end
  end

  // Line RAM: each word holds the 2*RADIUS rows above the current item.
  mf5x5_ram #(
    .WIDTH (NL * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ce && s1_valid),
    .waddr (s1_col),
    .wdata (col_word),
    .re    (ce),
    .raddr (in_col),
    .rdata (rd_word)
  );

  always_comb begin
    vec[0] = s1_pix;
    for (int k = 0; k < NL; k++) begin
      vec[k+1] = s1_fwd ? fwd_word[k*PIX_W +: PIX_W] : rd_word[k*PIX_W +: PIX_W];
    end
    for (int k = 0; k < NL; k++) begin
      col_word[k*PIX_W +: PIX_W] = vec[k];
    end
  end

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      colmax_next[j] = '0;
      for (int i = 0; i < NR; i++) begin
        if (s2_rmask[i]) begin
          colmax_next[j] = max2(colmax_next[j], win[j][i]);
        end
      end
    end
    best = '0;
    for (int j = 0; j < NR; j++) begin
      if (s3_cmask[j]) begin
        best = max2(best, colmax[j]);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ce) begin
      // When the item just read hits the column being written back this
      // cycle, the RAM returns the old word, so keep the new one aside.
      s1_fwd   <= s1_valid && (s1_col == in_col);
      fwd_word <= col_word;
      s1_col   <= in_col;
      s1_pix   <= (!s_axis_tuser && pix_ok) ? s_axis_tdata : '0;
      s1_last  <= q_last;
      s1_rmask <= rmask;
      s1_cmask <= cmask;
      if (s1_valid) begin
        win[0] <= vec;
        for (int j = 1; j < NR; j++) begin
          win[j] <= win[j-1];
        end
      end
      s2_last      <= s1_last;
      s2_rmask     <= s1_rmask;
      s2_cmask     <= s1_cmask;
      s3_last      <= s2_last;
      s3_cmask     <= s2_cmask;
      colmax       <= colmax_next;
      m_axis_tdata <= best;
      m_axis_tlast <= s3_last;
    end
  end

endmodule
